[sv/base58check_decoder_assert.svh]
// Assertion macros for the base58check decoder checker.
// Used by the checker file only; depends on nothing else.
`ifndef BASE58CHECK_DECODER_ASSERT_SVH
`define BASE58CHECK_DECODER_ASSERT_SVH
`define B58_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define B58_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

[sv/b58_pkg.sv]
// Package for the base58check decoder: payload types, sizes, codes, tables.
// No dependencies.
package b58_pkg;
    localparam int MAX_CHARS   = 128;
    localparam int STORE_BYTES = 96;
    localparam int MAX_DATA    = 32;
    localparam int RESULT_SLOTS = 32;
    localparam int MSG_CAP     = MAX_CHARS + STORE_BYTES + 8;
    localparam int SIDX_W      = $clog2(STORE_BYTES + 1);
    localparam int CCNT_W      = $clog2(MAX_CHARS + 2);
    localparam int MLEN_W      = $clog2(MSG_CAP + 1);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_CHAR = 3'd1;
    localparam logic [2:0] ST_BAD_LEN  = 3'd2;
    localparam logic [2:0] ST_BAD_SUM  = 3'd3;
    localparam logic [2:0] ST_OVER_CAP = 3'd4;

    typedef struct packed {
        logic [7:0] char_code;
        logic       last_char;
    } b58_in_t;

    typedef struct packed {
        logic [2:0] status;
        logic [7:0] prefix_byte;
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       last_result;
    } b58_out_t;

    // returns {invalid, digit}
    function automatic logic [6:0] digit_of(input logic [7:0] c);
        logic [6:0] r;
        r = 7'h7f;
        case (c)
            "r": r = 7'd0;  "p": r = 7'd1;  "s": r = 7'd2;  "h": r = 7'd3;
            "n": r = 7'd4;  "a": r = 7'd5;  "f": r = 7'd6;  "3": r = 7'd7;
            "9": r = 7'd8;  "w": r = 7'd9;  "B": r = 7'd10; "U": r = 7'd11;
            "D": r = 7'd12; "N": r = 7'd13; "E": r = 7'd14; "G": r = 7'd15;
            "H": r = 7'd16; "J": r = 7'd17; "K": r = 7'd18; "L": r = 7'd19;
            "M": r = 7'd20; "4": r = 7'd21; "P": r = 7'd22; "Q": r = 7'd23;
            "R": r = 7'd24; "S": r = 7'd25; "T": r = 7'd26; "7": r = 7'd27;
            "V": r = 7'd28; "W": r = 7'd29; "X": r = 7'd30; "Y": r = 7'd31;
            "Z": r = 7'd32; "2": r = 7'd33; "b": r = 7'd34; "c": r = 7'd35;
            "d": r = 7'd36; "e": r = 7'd37; "C": r = 7'd38; "g": r = 7'd39;
            "6": r = 7'd40; "5": r = 7'd41; "j": r = 7'd42; "k": r = 7'd43;
            "m": r = 7'd44; "8": r = 7'd45; "o": r = 7'd46; "F": r = 7'd47;
            "q": r = 7'd48; "i": r = 7'd49; "1": r = 7'd50; "t": r = 7'd51;
            "u": r = 7'd52; "v": r = 7'd53; "A": r = 7'd54; "x": r = 7'd55;
            "y": r = 7'd56; "z": r = 7'd57;
            default: r = 7'h7f;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sha_k(input logic [5:0] t);
        logic [31:0] k [64];
        k = '{32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
              32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
              32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
              32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
              32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
              32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
              32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
              32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
              32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
              32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
              32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        return k[t];
    endfunction

    function automatic logic [31:0] sha_iv(input logic [2:0] i);
        logic [31:0] v [8];
        v = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
              32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        return v[i];
    endfunction
endpackage

[sv/b58_sha.sv]
// Iterative SHA-256 compression unit: one round per cycle, 64 rounds per block.
// Depends on b58_pkg.
module b58_sha
    import b58_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         init,       // load IV
    input  logic         start,      // compress block_in
    input  logic [511:0] block_in,
    output logic         busy,
    output logic [255:0] digest
);
    logic [31:0] h_reg [8];
    logic [31:0] a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, hh_reg;
    logic [31:0] w_reg [16];
    logic [5:0]  t_reg;
    logic        run_reg, fin_reg;

    logic [31:0] w_cur, s0, s1, w_new, t1, t2, w15, w2;

    always_comb begin
        w15 = w_reg[1];
        w2  = w_reg[14];
        s0  = {w15[6:0], w15[31:7]} ^ {w15[17:0], w15[31:18]} ^ (w15 >> 3);
        s1  = {w2[16:0], w2[31:17]} ^ {w2[18:0], w2[31:19]} ^ (w2 >> 10);
        w_new = w_reg[0] + s0 + w_reg[9] + s1;
        w_cur = w_reg[0];
        t1 = hh_reg + ({e_reg[5:0], e_reg[31:6]} ^ {e_reg[10:0], e_reg[31:11]}
             ^ {e_reg[24:0], e_reg[31:25]}) + ((e_reg & f_reg) ^ (~e_reg & g_reg))
             + sha_k(t_reg) + w_cur;
        t2 = ({a_reg[1:0], a_reg[31:2]} ^ {a_reg[12:0], a_reg[31:13]}
             ^ {a_reg[21:0], a_reg[31:22]})
             + ((a_reg & b_reg) ^ (a_reg & c_reg) ^ (b_reg & c_reg));
    end

    assign busy = run_reg | fin_reg;

    always_comb begin
        for (int i = 0; i < 8; i++) begin
            digest[255-32*i -: 32] = h_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg <= 1'b0;
            fin_reg <= 1'b0;
            t_reg   <= '0;
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_iv(3'(i));
        end else if (init) begin
            for (int i = 0; i < 8; i++) h_reg[i] <= sha_iv(3'(i));
        end else if (start) begin
            run_reg <= 1'b1;
            t_reg   <= '0;
            for (int i = 0; i < 16; i++) w_reg[i] <= block_in[511-32*i -: 32];
            a_reg <= h_reg[0]; b_reg <= h_reg[1]; c_reg <= h_reg[2]; d_reg <= h_reg[3];
            e_reg <= h_reg[4]; f_reg <= h_reg[5]; g_reg <= h_reg[6]; hh_reg <= h_reg[7];
        end else if (run_reg) begin
            // window shifts: w_reg[0] is W[t]
            for (int i = 0; i < 15; i++) w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            hh_reg <= g_reg; g_reg <= f_reg; f_reg <= e_reg; e_reg <= d_reg + t1;
            d_reg <= c_reg; c_reg <= b_reg; b_reg <= a_reg; a_reg <= t1 + t2;
            t_reg <= t_reg + 6'd1;
            if (t_reg == 6'd63) begin
                run_reg <= 1'b0;
                fin_reg <= 1'b1;
            end
        end else if (fin_reg) begin
            fin_reg <= 1'b0;
            h_reg[0] <= h_reg[0] + a_reg; h_reg[1] <= h_reg[1] + b_reg;
            h_reg[2] <= h_reg[2] + c_reg; h_reg[3] <= h_reg[3] + d_reg;
            h_reg[4] <= h_reg[4] + e_reg; h_reg[5] <= h_reg[5] + f_reg;
            h_reg[6] <= h_reg[6] + g_reg; h_reg[7] <= h_reg[7] + hh_reg;
        end
    end
endmodule

[sv/base58check_decoder.sv]
// Base58Check decoder top level: character intake, byte-serial multiply-accumulate,
// SHA-256 sequencing and result output. Depends on b58_pkg and b58_sha.
// Each character runs the whole store through a shared 8x6 multiply-add, one store byte
// at a time (a read, then a write). The last character adds a scan of the store, then
// per hash block a fill and the rounds (one or more blocks for the first pass, one for the
// second), and then the results one by one. One string in flight.
// Reset: synchronous active low; then a clearing pass over every byte of the store.
module base58check_decoder
    import b58_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_we,
    input  logic [5:0] cfg_wdata,
    input  logic       s_valid,
    output logic       s_ready,
    input  b58_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output b58_out_t   m_data
);
    typedef enum logic [12:0] {
        S_CLEAR = 13'h0001, S_IDLE  = 13'h0002, S_MAC   = 13'h0004, S_SCAN  = 13'h0008,
        S_CHK   = 13'h0010, S_FILL  = 13'h0020, S_HASH  = 13'h0040, S_HWAIT = 13'h0080,
        S_H2    = 13'h0100, S_CMP   = 13'h0200, S_OUT   = 13'h0400, S_ERR   = 13'h0800,
        S_WAIT  = 13'h1000
    } state_t;

    localparam int SI_W = $clog2(STORE_BYTES);

    state_t              state_reg;
    logic [5:0]          cap_reg;
    logic [7:0]          store [STORE_BYTES];
    logic [7:0]          rd_reg;
    logic [SI_W-1:0]     idx_reg;
    logic [5:0]          carry_reg;
    logic [CCNT_W-1:0]   ccount_reg;
    logic [CCNT_W-1:0]   zcount_reg;
    logic                zrun_reg;
    logic                err_reg;
    logic                last_reg;
    logic [SIDX_W-1:0]   start_reg;
    logic [MLEN_W-1:0]   rlen_reg;
    logic [MLEN_W-1:0]   pos_reg;     // message byte position being fed
    logic [MLEN_W-1:0]   mlen_reg;    // length of the current hash message
    logic [6:0]          bpos_reg;    // byte within block
    logic [511:0]        blk_reg;
    logic                pass2_reg;
    logic                pend_reg;    // store read in flight
    logic [255:0]        h1_reg;
    logic [7:0]          msg_rd;
    logic [7:0]          prefix_reg;
    logic [31:0]         sum_reg;
    logic [5:0]          dlen_reg;
    logic [5:0]          ocnt_reg;
    logic [2:0]          status_reg;
    logic                scanrd_reg;
    logic                mvalid_reg;
    b58_out_t            mdata_reg;

    logic                sha_init, sha_start, sha_busy;
    logic [255:0]        sha_dig;

    b58_sha u_sha (
        .aclk, .aresetn, .init(sha_init), .start(sha_start),
        .block_in(blk_reg), .busy(sha_busy), .digest(sha_dig)
    );

    logic [6:0]  dig;
    logic [13:0] mac;
    logic [5:0]  cap_eff;
    logic [MLEN_W-1:0] total;

    assign dig   = digit_of(s_data.char_code);
    assign mac   = ({6'b000000, rd_reg} * 14'd58) + {8'h00, carry_reg};
    assign cap_eff = (cap_reg > 6'(MAX_DATA)) ? 6'(MAX_DATA) : cap_reg;
    // padded length rounded up to 64-byte blocks
    assign total = MLEN_W'(((mlen_reg + MLEN_W'(9) + MLEN_W'(63)) >> 6) << 6);

    assign s_ready = (state_reg == S_IDLE) && !mvalid_reg;
    assign m_valid = mvalid_reg;
    assign m_data  = mdata_reg;

    // message byte at position pos (pass one: zeros then store; pass two: first digest; then padding)
    logic [7:0] pad_byte;
    logic [MLEN_W-1:0] msg_pos_store;
    logic [63:0] bitlen;
    always_comb begin
        bitlen = 64'(mlen_reg) << 3;
        msg_pos_store = pos_reg - zcount_reg + MLEN_W'(start_reg);
        if (pos_reg < mlen_reg) begin
            if (pass2_reg) pad_byte = h1_reg[255 - 8*pos_reg[4:0] -: 8];
            else if (pos_reg < MLEN_W'(zcount_reg)) pad_byte = 8'h00;
            else pad_byte = msg_rd;
        end else if (pos_reg == mlen_reg) begin
            pad_byte = 8'h80;
        end else if (pos_reg >= total - MLEN_W'(8)) begin
            pad_byte = bitlen[8*(total - MLEN_W'(1) - pos_reg) +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    assign sha_init  = (state_reg == S_CHK) || (state_reg == S_H2);
    assign sha_start = (state_reg == S_HASH);

    always_ff @(posedge aclk) begin
        if (state_reg == S_CLEAR) store[idx_reg] <= 8'h00;
        else if (state_reg == S_MAC && pend_reg) store[idx_reg] <= mac[7:0];
        else if (state_reg == S_WAIT && mvalid_reg == 1'b0) store[idx_reg] <= 8'h00;
        rd_reg <= store[idx_reg];
        msg_rd <= store[msg_pos_store[SI_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            cap_reg    <= 6'd32;
            idx_reg    <= '0;
            ccount_reg <= '0;
            zcount_reg <= '0;
            zrun_reg   <= 1'b1;
            err_reg    <= 1'b0;
            mvalid_reg <= 1'b0;
            pend_reg   <= 1'b0;
            scanrd_reg <= 1'b0;
            ocnt_reg   <= '0;
        end else begin
            if (cfg_we) cap_reg <= cfg_wdata;
            if (mvalid_reg && m_ready) mvalid_reg <= 1'b0;
            case (state_reg)
                S_CLEAR: begin
                    idx_reg <= idx_reg + SI_W'(1);
                    if (idx_reg == SI_W'(STORE_BYTES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_valid && s_ready) begin
                        last_reg <= s_data.last_char;
                        if (ccount_reg <= CCNT_W'(MAX_CHARS))
                            ccount_reg <= ccount_reg + CCNT_W'(1);
                        if (ccount_reg < CCNT_W'(MAX_CHARS) && !err_reg) begin
                            if (dig[6]) begin
                                err_reg <= 1'b1;
                                idx_reg <= '0;
                                state_reg <= s_data.last_char ? S_SCAN : S_IDLE;
                            end else begin
                                if (zrun_reg && s_data.char_code == "r")
                                    zcount_reg <= zcount_reg + CCNT_W'(1);
                                else zrun_reg <= 1'b0;
                                carry_reg <= dig[5:0];
                                idx_reg   <= SI_W'(STORE_BYTES - 1);
                                pend_reg  <= 1'b0;
                                state_reg <= S_MAC;
                            end
                        end else if (s_data.last_char) begin
                            idx_reg   <= '0;
                            state_reg <= S_SCAN;
                        end
                        start_reg  <= '0;
                        scanrd_reg <= 1'b0;
                    end
                end
                S_MAC: begin
                    // read one cycle, write next
                    if (!pend_reg) begin
                        pend_reg <= 1'b1;
                    end else begin
                        carry_reg <= mac[13:8];
                        pend_reg  <= 1'b0;
                        if (idx_reg == '0) begin
                            state_reg  <= last_reg ? S_SCAN : S_IDLE;
                            start_reg  <= '0;
                            scanrd_reg <= 1'b0;
                        end else begin
                            idx_reg <= idx_reg - SI_W'(1);
                        end
                    end
                end
                S_SCAN: begin
                    // count leading zero bytes
                    if (err_reg || ccount_reg > CCNT_W'(MAX_CHARS)) begin
                        state_reg <= S_CHK;
                    end else if (!scanrd_reg) begin
                        scanrd_reg <= 1'b1;
                    end else begin
                        scanrd_reg <= 1'b0;
                        if (rd_reg != 8'h00 || start_reg == SIDX_W'(STORE_BYTES - 1)) begin
                            if (rd_reg == 8'h00) start_reg <= SIDX_W'(STORE_BYTES);
                            state_reg <= S_CHK;
                        end else begin
                            start_reg <= start_reg + SIDX_W'(1);
                            idx_reg   <= idx_reg + SI_W'(1);
                        end
                    end
                end
                S_CHK: begin
                    rlen_reg <= MLEN_W'(zcount_reg) + MLEN_W'(STORE_BYTES) - MLEN_W'(start_reg);
                    mlen_reg <= MLEN_W'(zcount_reg) + MLEN_W'(STORE_BYTES)
                                - MLEN_W'(start_reg) - MLEN_W'(4);
                    if (ccount_reg > CCNT_W'(MAX_CHARS)) begin
                        status_reg <= ST_BAD_LEN; state_reg <= S_ERR;
                    end else if (err_reg) begin
                        status_reg <= ST_BAD_CHAR; state_reg <= S_ERR;
                    end else if (MLEN_W'(zcount_reg) + MLEN_W'(STORE_BYTES)
                                 - MLEN_W'(start_reg) < MLEN_W'(5)) begin
                        status_reg <= ST_BAD_LEN; state_reg <= S_ERR;
                    end else begin
                        status_reg <= ST_OK;
                        pass2_reg <= 1'b0;
                        pos_reg   <= '0;
                        bpos_reg  <= '0;
                        sum_reg   <= '0;
                        ocnt_reg  <= '0;
                        pend_reg  <= 1'b0;
                        state_reg <= S_FILL;
                    end
                end
                S_FILL: begin
                    // one byte at a time, each after a wait for the store read
                    if (!pend_reg) begin
                        pend_reg <= 1'b1;
                    end else begin
                        pend_reg <= 1'b0;
                        blk_reg <= {blk_reg[503:0], pad_byte};
                        if (!pass2_reg && pos_reg == MLEN_W'(0)) prefix_reg <= pad_byte;
                        pos_reg  <= pos_reg + MLEN_W'(1);
                        bpos_reg <= bpos_reg + 7'd1;
                        if (bpos_reg == 7'd63) state_reg <= S_HASH;
                    end
                end
                S_HASH: begin
                    bpos_reg  <= '0;
                    state_reg <= S_HWAIT;
                end
                S_HWAIT: begin
                    if (!sha_busy) begin
                        if (pos_reg < total) state_reg <= S_FILL;
                        else if (!pass2_reg) state_reg <= S_H2;
                        else state_reg <= S_CMP;
                    end
                end
                S_H2: begin
                    h1_reg    <= sha_dig;
                    pass2_reg <= 1'b1;
                    mlen_reg  <= MLEN_W'(32);
                    pos_reg   <= '0;
                    // hash the first digest as the second pass
                    state_reg <= S_FILL;
                end
                S_CMP: begin
                    // gather stored checksum: reuse pos_reg as offset
                    if (!pend_reg) begin
                        pend_reg <= 1'b1;
                        pos_reg  <= rlen_reg - MLEN_W'(4) + MLEN_W'(ocnt_reg[1:0]);
                        pass2_reg <= 1'b0;
                        mlen_reg  <= rlen_reg;
                    end else if (!scanrd_reg) begin
                        scanrd_reg <= 1'b1;
                    end else begin
                        scanrd_reg <= 1'b0;
                        pend_reg   <= 1'b0;
                        sum_reg <= {sum_reg[23:0], pad_byte};
                        ocnt_reg <= ocnt_reg + 6'd1;
                        if (ocnt_reg[1:0] == 2'd3) begin
                            ocnt_reg <= '0;
                            if ({sum_reg[23:0], pad_byte} != sha_dig[255:224]) begin
                                status_reg <= ST_BAD_SUM; state_reg <= S_ERR;
                            end else if (rlen_reg - MLEN_W'(5) > MLEN_W'(cap_eff)) begin
                                status_reg <= ST_OVER_CAP; state_reg <= S_ERR;
                            end else begin
                                dlen_reg <= 6'(rlen_reg - MLEN_W'(5));
                                pos_reg  <= MLEN_W'(1);
                                state_reg <= S_OUT;
                            end
                        end
                    end
                end
                S_OUT: begin
                    if (!mvalid_reg || m_ready) begin
                        if (!pend_reg) begin
                            pend_reg <= 1'b1;
                        end else begin
                            pend_reg <= 1'b0;
                            mvalid_reg <= 1'b1;
                            mdata_reg.status      <= ST_OK;
                            mdata_reg.prefix_byte <= prefix_reg;
                            mdata_reg.data_byte   <= (dlen_reg == '0) ? 8'h00 : pad_byte;
                            mdata_reg.byte_valid  <= (dlen_reg != '0);
                            mdata_reg.last_result <= (dlen_reg == '0)
                                                     || (MLEN_W'(dlen_reg) == pos_reg);
                            pos_reg <= pos_reg + MLEN_W'(1);
                            if (dlen_reg == '0 || MLEN_W'(dlen_reg) == pos_reg) begin
                                state_reg <= S_WAIT;
                                idx_reg   <= '0;
                            end
                        end
                    end
                end
                S_ERR: begin
                    if (!mvalid_reg || m_ready) begin
                        mvalid_reg <= 1'b1;
                        mdata_reg  <= '{status: status_reg, prefix_byte: 8'h00,
                                       data_byte: 8'h00, byte_valid: 1'b0,
                                       last_result: 1'b1};
                        state_reg  <= S_WAIT;
                        idx_reg    <= '0;
                    end
                end
                S_WAIT: begin
                    // clear the store for the next string
                    if (!mvalid_reg) begin
                        idx_reg <= idx_reg + SI_W'(1);
                        if (idx_reg == SI_W'(STORE_BYTES - 1)) begin
                            state_reg  <= S_IDLE;
                            ccount_reg <= '0;
                            zcount_reg <= '0;
                            zrun_reg   <= 1'b1;
                            err_reg    <= 1'b0;
                        end
                    end
                end
                default: state_reg <= S_CLEAR;
            endcase
        end
    end
endmodule

[sv/b58_checker.sv]
// Port-level checker for base58check_decoder, bound to the top level.
// Depends on b58_pkg and base58check_decoder_assert.svh.
`include "base58check_decoder_assert.svh"
module b58_checker
    import b58_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input b58_out_t m_data
);
    logic is_err;
    logic err_shape;
    logic err_zero;

    assign is_err    = m_valid && m_data.status != ST_OK;
    assign err_shape = m_data.last_result && !m_data.byte_valid;
    assign err_zero  = m_data.prefix_byte == 8'h00 && m_data.data_byte == 8'h00;

    `B58_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))
    `B58_ASSERT_IMPL(a_err_one, aclk, aresetn, is_err, err_shape)
    `B58_ASSERT_IMPL(a_err_zero, aclk, aresetn, is_err, err_zero)
    `B58_ASSERT_IMPL(a_no_overlap, aclk, aresetn, m_valid, !s_ready)
endmodule

bind base58check_decoder b58_checker u_b58_checker (
    .aclk, .aresetn, .s_ready, .m_valid, .m_ready, .m_data
);

[sim/tb_base58check_decoder.sv]
// Self-checking testbench for base58check_decoder: directed and random strings with
// random handshake idling, checked against a built-in decode and double SHA-256 model.
// Depends on b58_pkg and the base58check_decoder RTL.
module tb_base58check_decoder;
    timeunit 1ns;
    timeprecision 1ps;
    import b58_pkg::*;

    typedef logic [7:0] byte_q_t [$];

    localparam int    WATCHDOG_LIMIT = 20000;
    localparam int    HOLD_CYCLES    = 1500;
    localparam int    DRAIN_CYCLES   = 300;
    localparam string ALPHABET = "rpshnaf39wBUDNEGHJKLM4PQRST7VWXYZ2bcdeCg65jkm8oFqi1tuvAxyz";
    localparam logic [31:0] HASH_IV [0:7] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
    localparam logic [31:0] ROUND_K [0:63] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function automatic byte_q_t sha256(input byte_q_t msg);
        logic [31:0] h [8];
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, hh, t1, t2;
        logic [63:0] bits;
        byte_q_t p;
        byte_q_t dig;
        p = msg;
        bits = 64'(msg.size()) * 8;
        p.push_back(8'h80);
        while (p.size() % 64 != 56) p.push_back(8'h00);
        for (int i = 7; i >= 0; i--) p.push_back(bits[8*i +: 8]);
        for (int i = 0; i < 8; i++) h[i] = HASH_IV[i];
        for (int blk = 0; blk < p.size() / 64; blk++) begin
            for (int t = 0; t < 16; t++)
                w[t] = {p[blk*64+4*t], p[blk*64+4*t+1], p[blk*64+4*t+2], p[blk*64+4*t+3]};
            for (int t = 16; t < 64; t++)
                w[t] = (rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7]
                     + (rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
            a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4]; f = h[5]; g = h[6]; hh = h[7];
            for (int t = 0; t < 64; t++) begin
                t1 = hh + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                   + ROUND_K[t] + w[t];
                t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
                hh = g; g = f; f = e; e = d + t1; d = c; c = b; b = a; a = t1 + t2;
            end
            h[0] += a; h[1] += b; h[2] += c; h[3] += d;
            h[4] += e; h[5] += f; h[6] += g; h[7] += hh;
        end
        for (int i = 0; i < 32; i++) dig.push_back(h[i/4][8*(3-i%4) +: 8]);
        return dig;
    endfunction

    function automatic int digit_value(input logic [7:0] ch);
        for (int i = 0; i < 58; i++)
            if (ALPHABET[i] == ch) return i;
        return -1;
    endfunction

    class decoder_scoreboard;
        logic [7:0] number [STORE_BYTES];
        int         char_cnt;
        int         zero_chars;
        bit         zero_run;
        logic [2:0] err_code;
        int         cap_reg;
        b58_out_t   expected_q [$];
        int         errors;
        int         results;
        int         status_cnt [5];

        function new();
            cap_reg = 32;
            clear_string();
        endfunction

        function void clear_string();
            foreach (number[j]) number[j] = 8'h00;
            char_cnt = 0;
            zero_chars = 0;
            zero_run = 1;
            err_code = ST_OK;
        endfunction

        function void push_result(logic [2:0] st, logic [7:0] pre, logic [7:0] db,
                                  logic bv, logic lr);
            b58_out_t r;
            r.status = st; r.prefix_byte = pre; r.data_byte = db;
            r.byte_valid = bv; r.last_result = lr;
            expected_q.push_back(r);
        endfunction

        function void note_request(b58_in_t req);
            int d, carry, start, rlen, dlen, cap;
            logic [2:0] st;
            byte_q_t msg, body, h2;
            if (char_cnt <= MAX_CHARS) char_cnt++;
            if (char_cnt <= MAX_CHARS && err_code == ST_OK) begin
                d = digit_value(req.char_code);
                if (d < 0) begin
                    err_code = ST_BAD_CHAR;
                end else begin
                    if (zero_run && req.char_code == "r") zero_chars++;
                    else zero_run = 0;
                    carry = d;
                    for (int j = STORE_BYTES - 1; j >= 0; j--) begin
                        carry += 58 * number[j];
                        number[j] = carry[7:0];
                        carry = carry >> 8;
                    end
                end
            end
            if (!req.last_char) return;
            start = 0;
            while (start < STORE_BYTES && number[start] == 0) start++;
            rlen = zero_chars + STORE_BYTES - start;
            st = ST_OK;
            if (char_cnt > MAX_CHARS) st = ST_BAD_LEN;
            else if (err_code != ST_OK) st = ST_BAD_CHAR;
            else if (rlen < 5 || rlen > MSG_CAP) st = ST_BAD_LEN;
            if (st == ST_OK) begin
                for (int i = 0; i < zero_chars; i++) msg.push_back(8'h00);
                for (int j = start; j < STORE_BYTES; j++) msg.push_back(number[j]);
                body = msg[0:rlen-5];
                h2 = sha256(sha256(body));
                for (int i = 0; i < 4; i++)
                    if (h2[i] != msg[rlen-4+i]) st = ST_BAD_SUM;
            end
            cap = cap_reg;
            if (cap > MAX_DATA) cap = MAX_DATA;
            if (cap > RESULT_SLOTS) cap = RESULT_SLOTS;
            dlen = (st == ST_OK) ? rlen - 5 : 0;
            if (st == ST_OK && dlen > cap) st = ST_OVER_CAP;
            status_cnt[st]++;
            if (st != ST_OK) push_result(st, 8'h00, 8'h00, 1'b0, 1'b1);
            else if (dlen == 0) push_result(ST_OK, msg[0], 8'h00, 1'b0, 1'b1);
            else
                for (int i = 0; i < dlen; i++)
                    push_result(ST_OK, msg[0], msg[1+i], 1'b1, i + 1 == dlen);
            clear_string();
        endfunction

        task report(input string what);
            errors++;
            $display("[%0t] MISMATCH: %s", $realtime, what);
        endtask

        task check_result(input b58_out_t got);
            b58_out_t want;
            results++;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result %h", got));
                return;
            end
            want = expected_q.pop_front();
            if (got.status != want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.prefix_byte != want.prefix_byte)
                report($sformatf("prefix %h, want %h", got.prefix_byte, want.prefix_byte));
            if (got.data_byte != want.data_byte)
                report($sformatf("data %h, want %h", got.data_byte, want.data_byte));
            if (got.byte_valid != want.byte_valid)
                report($sformatf("byte_valid %b, want %b", got.byte_valid, want.byte_valid));
            if (got.last_result != want.last_result)
                report($sformatf("last %b, want %b", got.last_result, want.last_result));
        endtask
    endclass

    logic     aclk;
    logic     aresetn;
    logic     cfg_we;
    logic [5:0] cfg_wdata;
    logic     s_valid;
    logic     s_ready;
    b58_in_t  s_data;
    logic     m_valid;
    logic     m_ready;
    b58_out_t m_data;

    decoder_scoreboard sb;
    int  tx_idle_pct;
    int  rx_idle_pct;
    bit  hold_req;
    int  chars_sent;
    int  strings_sent;
    int  stall_cycles;

    base58check_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            stall_cycles++;
            if (s_valid && s_ready) begin
                sb.note_request(s_data);
                stall_cycles = 0;
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
                stall_cycles = 0;
            end
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("Timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    task send_char(input logic [7:0] ch, input logic last);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data.char_code <= ch;
        s_data.last_char <= last;
        do @(posedge aclk); while (!s_ready);
        chars_sent++;
    endtask

    task send_string(input byte_q_t str);
        foreach (str[i]) send_char(str[i], i == str.size() - 1);
        s_valid <= 1'b0;
        @(posedge aclk);
        strings_sent++;
    endtask

    task write_capacity(input logic [5:0] value);
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        sb.cap_reg = value;
    endtask

    function automatic byte_q_t encode(input byte_q_t raw);
        int digits [$];
        int carry, nz;
        byte_q_t str;
        nz = 0;
        while (nz < raw.size() && raw[nz] == 0) nz++;
        foreach (raw[i]) begin
            carry = raw[i];
            foreach (digits[j]) begin
                carry += digits[j] * 256;
                digits[j] = carry % 58;
                carry = carry / 58;
            end
            while (carry > 0) begin
                digits.push_back(carry % 58);
                carry = carry / 58;
            end
        end
        repeat (nz) str.push_back("r");
        for (int j = digits.size() - 1; j >= 0; j--) str.push_back(ALPHABET[digits[j]]);
        return str;
    endfunction

    function automatic byte_q_t make_address(input int dlen);
        byte_q_t raw, h2;
        raw.push_back(($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        repeat (dlen) raw.push_back(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom));
        h2 = sha256(sha256(raw));
        for (int i = 0; i < 4; i++) raw.push_back(h2[i]);
        return encode(raw);
    endfunction

    function automatic logic [7:0] any_symbol();
        return ALPHABET[$urandom_range(0, 57)];
    endfunction

    task send_random_string(input int cap);
        byte_q_t str;
        int kind, dlen, pos;
        kind = $urandom_range(0, 99);
        case ($urandom_range(0, 3))
            0: dlen = cap;
            1: dlen = cap + 1;
            default: dlen = $urandom_range(0, (cap < 8) ? cap : 8);
        endcase
        if (dlen > 32) dlen = 32;
        str = make_address(dlen);
        if (kind >= 70 && kind < 80) begin
            pos = $urandom_range(0, str.size() - 1);
            str[pos] = any_symbol();
        end else if (kind >= 80 && kind < 88) begin
            str.delete();
            repeat ($urandom_range(1, 10)) str.push_back(8'($urandom));
        end else if (kind >= 88 && kind < 93) begin
            str.delete();
            repeat ($urandom_range(1, 7))
                str.push_back(($urandom_range(0, 1) == 0) ? 8'("r") : any_symbol());
        end else if (kind >= 93 && kind < 97) begin
            pos = $urandom_range(0, str.size() - 1);
            str.insert(pos, ($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom));
        end else if (kind >= 97) begin
            str.delete();
            repeat ($urandom_range(MAX_CHARS + 1, MAX_CHARS + 12)) str.push_back(any_symbol());
        end
        send_string(str);
    endtask

    task run_phase(input int tx_pct, input int rx_pct, input logic [5:0] cap_value,
                   input int n_chars, input bit with_hold);
        int target, strings_at, cap;
        write_capacity(cap_value);
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        cap = (cap_value > MAX_DATA) ? MAX_DATA : cap_value;
        if (with_hold) hold_req = 1;
        target = chars_sent + n_chars;
        strings_at = strings_sent;
        while (chars_sent < target || strings_sent - strings_at < 15)
            send_random_string(cap);
    endtask

    initial begin
        byte_q_t str;
        sb = new();
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= 6'd0;
        s_valid <= 1'b0;
        s_data <= '0;
        tx_idle_pct = 31;
        rx_idle_pct = 45;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // short and malformed strings, then minimal and empty-data addresses
        str = '{8'("p")};                              send_string(str);
        str = '{8'h00};                                send_string(str);
        str = '{8'hff, 8'("p")};                       send_string(str);
        str = '{"r", "r", "r", "r", "r"};              send_string(str);
        str = '{"z", "z", "z"};                        send_string(str);
        send_string(make_address(0));
        write_capacity(6'd0);
        send_string(make_address(0));
        send_string(make_address(1));
        write_capacity(6'd63);

        run_phase(31, 45, 6'd63, 120, 1'b1);
        run_phase(45, 31, 6'd7, 110, 1'b0);
        run_phase(0, 0, 6'd32, 110, 1'b0);

        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.expected_q.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
        $display("Sent %0d strings (%0d characters); %0d results checked.",
                 strings_sent, chars_sent, sb.results);
        $display("Status mix: ok %0d, bad char %0d, bad length %0d, checksum %0d, cap %0d",
                 sb.status_cnt[0], sb.status_cnt[1], sb.status_cnt[2],
                 sb.status_cnt[3], sb.status_cnt[4]);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
